### sv/tag_writer_key_repeat_sequencer_assert.svh
// Assertion macros shared by the checker of the tag writer key repeat sequencer.
// No dependencies; every macro is clocked and disabled while reset is low.
`ifndef TAG_WRITER_KEY_REPEAT_SEQUENCER_ASSERT_SVH
`define TAG_WRITER_KEY_REPEAT_SEQUENCER_ASSERT_SVH

// Same-cycle implication.
`define TWKRS_ASSERT(lbl, clk, rst_n, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("twkrs assertion failed");

// Next-cycle implication.
`define TWKRS_ASSERT_NEXT(lbl, clk, rst_n, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("twkrs assertion failed");

`endif

### sv/twkrs_pkg.sv
// Package of the tag writer key repeat sequencer: types, codes and reset values.
// Used by the register file, the step logic and the top level.
`default_nettype none

package twkrs_pkg;

  localparam int unsigned AddrW = 5;
  localparam int unsigned DataW = 32;

  // Register indexes, taken from paddr[4:2].
  localparam logic [2:0] REG_DEBOUNCE      = 3'd0;
  localparam logic [2:0] REG_INITIAL_DELAY = 3'd1;
  localparam logic [2:0] REG_REPEAT_PERIOD = 3'd2;
  localparam logic [2:0] REG_POLL_PERIOD   = 3'd3;
  localparam logic [2:0] REG_RESULT_HOLD   = 3'd4;
  localparam logic [2:0] REG_EMPTY_NEEDED  = 3'd5;
  localparam logic [2:0] REG_TOP_NUMBER    = 3'd6;

  localparam logic [15:0] DEBOUNCE_RST      = 16'd25;
  localparam logic [15:0] INITIAL_DELAY_RST = 16'd500;
  localparam logic [15:0] REPEAT_PERIOD_RST = 16'd150;
  localparam logic [15:0] POLL_PERIOD_RST   = 16'd100;
  localparam logic [15:0] RESULT_HOLD_RST   = 16'd800;
  localparam logic [3:0]  EMPTY_NEEDED_RST  = 4'd3;
  localparam logic [9:0]  TOP_NUMBER_RST    = 10'd999;

  localparam logic [15:0] CNT_MAX   = 16'hFFFF;
  localparam logic [3:0]  EMPTY_MAX = 4'd15;
  localparam logic [9:0]  NUM_MIN   = 10'd1;

  // Key levels packed as {down, up}.
  localparam logic [1:0] KEYS_UP   = 2'b01;
  localparam logic [1:0] KEYS_DOWN = 2'b10;

  localparam logic [1:0] OUTCOME_NONE = 2'd0;
  localparam logic [1:0] OUTCOME_OK   = 2'd1;

  localparam logic [1:0] SHOWN_NONE = 2'd0;
  localparam logic [1:0] SHOWN_OK   = 2'd1;
  localparam logic [1:0] SHOWN_ERR  = 2'd2;

  typedef struct packed {
    logic [15:0] debounce_ticks;
    logic [15:0] initial_delay;
    logic [15:0] repeat_period;
    logic [15:0] poll_period;
    logic [15:0] result_hold;
    logic [3:0]  empty_needed;
    logic [9:0]  top_number;
  } cfg_t;

  typedef struct packed {
    logic       key_up;
    logic       key_down;
    logic [1:0] write_outcome;
    logic       field_empty;
  } item_t;

  typedef struct packed {
    logic        mode_removing;
    logic [9:0]  number;
    logic [1:0]  raw_keys;
    logic [1:0]  stable_keys;
    logic [15:0] since_key_change;
    logic [15:0] since_step;
    logic        in_repeat;
    logic [15:0] since_poll;
    logic [15:0] since_result;
    logic [3:0]  empty_count;
    logic        last_ok;
    logic        prompt_done;
  } state_t;

  typedef struct packed {
    logic [9:0] selected;
    logic       removing;
    logic       number_changed;
    logic       write_slot;
    logic [1:0] result_shown;
    logic       removal_prompt;
  } res_t;

  localparam state_t STATE_RST = '{
    mode_removing:    1'b0,
    number:           NUM_MIN,
    raw_keys:         2'b00,
    stable_keys:      2'b00,
    since_key_change: 16'd0,
    since_step:       16'd0,
    in_repeat:        1'b0,
    since_poll:       16'd0,
    since_result:     16'd0,
    empty_count:      4'd0,
    last_ok:          1'b0,
    prompt_done:      1'b0
  };

endpackage

`default_nettype wire

### sv/twkrs_cfg_regs.sv
// APB-style configuration registers of the tag writer key repeat sequencer.
// Depends on twkrs_pkg for the register indexes, reset values and cfg_t.
`default_nettype none

module twkrs_cfg_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [twkrs_pkg::AddrW-1:0]   paddr,
  input  logic [twkrs_pkg::DataW-1:0]   pwdata,
  output logic [twkrs_pkg::DataW-1:0]   prdata,
  output logic                          pready,
  output twkrs_pkg::cfg_t               cfg_o
);
  import twkrs_pkg::*;

  cfg_t       cfg_q, cfg_d;
  logic [2:0] idx;
  logic       wr_en;

  assign pready = 1'b1;
  assign idx    = paddr[AddrW-1:2];
  assign wr_en  = psel && penable && pwrite && pready;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (idx)
        REG_DEBOUNCE:      cfg_d.debounce_ticks = pwdata[15:0];
        REG_INITIAL_DELAY: cfg_d.initial_delay  = pwdata[15:0];
        REG_REPEAT_PERIOD: cfg_d.repeat_period  = pwdata[15:0];
        REG_POLL_PERIOD:   cfg_d.poll_period    = pwdata[15:0];
        REG_RESULT_HOLD:   cfg_d.result_hold    = pwdata[15:0];
        REG_EMPTY_NEEDED:  cfg_d.empty_needed   = pwdata[3:0];
        REG_TOP_NUMBER:    cfg_d.top_number     = pwdata[9:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_DEBOUNCE:      prdata = {16'd0, cfg_q.debounce_ticks};
      REG_INITIAL_DELAY: prdata = {16'd0, cfg_q.initial_delay};
      REG_REPEAT_PERIOD: prdata = {16'd0, cfg_q.repeat_period};
      REG_POLL_PERIOD:   prdata = {16'd0, cfg_q.poll_period};
      REG_RESULT_HOLD:   prdata = {16'd0, cfg_q.result_hold};
      REG_EMPTY_NEEDED:  prdata = {28'd0, cfg_q.empty_needed};
      REG_TOP_NUMBER:    prdata = {22'd0, cfg_q.top_number};
      default:           prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.debounce_ticks <= DEBOUNCE_RST;
      cfg_q.initial_delay  <= INITIAL_DELAY_RST;
      cfg_q.repeat_period  <= REPEAT_PERIOD_RST;
      cfg_q.poll_period    <= POLL_PERIOD_RST;
      cfg_q.result_hold    <= RESULT_HOLD_RST;
      cfg_q.empty_needed   <= EMPTY_NEEDED_RST;
      cfg_q.top_number     <= TOP_NUMBER_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

### sv/twkrs_step.sv
// Combinational tick step of the tag writer key repeat sequencer: next state and result.
// Depends on twkrs_pkg for cfg_t, item_t, state_t, res_t and the codes.
`default_nettype none

module twkrs_step (
  input  twkrs_pkg::cfg_t   cfg_i,
  input  twkrs_pkg::state_t state_i,
  input  twkrs_pkg::item_t  item_i,
  output twkrs_pkg::state_t state_o,
  output twkrs_pkg::res_t   res_o
);
  import twkrs_pkg::*;

  function automatic logic [15:0] tick_up(input logic [15:0] c);
    return (c == CNT_MAX) ? c : c + 16'd1;
  endfunction

  function automatic logic [9:0] step_num(input logic [1:0] keys, input logic [9:0] num,
                                          input logic [9:0] top);
    logic [9:0] r;
    r = num;
    if (keys == KEYS_UP && num < top) begin
      r = num + 10'd1;
    end else if (keys == KEYS_DOWN && num > NUM_MIN) begin
      r = num - 10'd1;
    end
    return r;
  endfunction

  state_t     s;
  logic [1:0] keys;
  logic [3:0] empty_inc;
  logic       slot;
  logic [1:0] shown;
  logic       prompt;

  assign keys = {item_i.key_down, item_i.key_up};

  always_comb begin
    s      = state_i;
    slot   = 1'b0;
    shown  = SHOWN_NONE;
    prompt = 1'b0;
    empty_inc = '0;

    s.since_key_change = tick_up(state_i.since_key_change);
    s.since_step       = tick_up(state_i.since_step);
    s.since_poll       = tick_up(state_i.since_poll);
    s.since_result     = tick_up(state_i.since_result);

    if (keys != s.raw_keys) begin
      s.raw_keys         = keys;
      s.since_key_change = '0;
    end

    // While removing, keys are tracked but never step, so nothing fires on return.
    if (s.mode_removing) begin
      s.stable_keys = s.raw_keys;
      s.since_step  = '0;
      s.in_repeat   = 1'b0;
    end else if (s.since_key_change >= cfg_i.debounce_ticks) begin
      if (s.stable_keys != s.raw_keys) begin
        s.stable_keys = s.raw_keys;
        s.since_step  = '0;
        s.in_repeat   = 1'b0;
        s.number      = step_num(s.raw_keys, s.number, cfg_i.top_number);
      end else if (s.stable_keys == KEYS_UP || s.stable_keys == KEYS_DOWN) begin
        if (s.since_step >= (s.in_repeat ? cfg_i.repeat_period : cfg_i.initial_delay)) begin
          s.since_step = '0;
          s.in_repeat  = 1'b1;
          s.number     = step_num(s.stable_keys, s.number, cfg_i.top_number);
        end
      end
    end

    if (s.since_poll >= cfg_i.poll_period) begin
      s.since_poll = '0;
      if (s.mode_removing) begin
        if (s.since_result >= cfg_i.result_hold) begin
          if (s.last_ok && !s.prompt_done) begin
            prompt        = 1'b1;
            s.prompt_done = 1'b1;
          end
          if (!item_i.field_empty) begin
            s.empty_count = '0;
          end else begin
            empty_inc = (s.empty_count < EMPTY_MAX) ? s.empty_count + 4'd1 : s.empty_count;
            s.empty_count = empty_inc;
            if (empty_inc >= cfg_i.empty_needed) begin
              s.empty_count = '0;
              if (s.last_ok && s.number < cfg_i.top_number) begin
                s.number = s.number + 10'd1;
              end
              s.mode_removing = 1'b0;
            end
          end
        end
      end else begin
        slot = 1'b1;
        // Any nonzero outcome other than success counts as an error.
        if (item_i.write_outcome != OUTCOME_NONE) begin
          s.last_ok       = (item_i.write_outcome == OUTCOME_OK);
          shown           = s.last_ok ? SHOWN_OK : SHOWN_ERR;
          s.empty_count   = '0;
          s.prompt_done   = 1'b0;
          s.since_result  = '0;
          s.mode_removing = 1'b1;
        end
      end
    end
  end

  assign state_o = s;

  assign res_o.selected       = s.number;
  assign res_o.removing       = s.mode_removing;
  assign res_o.number_changed = (s.number != state_i.number);
  assign res_o.write_slot     = slot;
  assign res_o.result_shown   = shown;
  assign res_o.removal_prompt = prompt;

endmodule

`default_nettype wire

### sv/tag_writer_key_repeat_sequencer.sv
// Top level of the tag writer key repeat sequencer: input register, state, result register.
// Depends on twkrs_pkg, twkrs_cfg_regs and twkrs_step.
//
// Each request is one millisecond tick and yields exactly one result. A request is
// taken into an input register; the tick step runs combinationally from that register
// into the state and the result register, and waits while the result is not taken.
// One request is accepted every cycle unless the output stalls. The input ready drops
// only while both the input register and the result register are full and the result
// is not taken. Configuration writes go through an APB-style port with registers at
// byte addresses 0x00 to 0x18 and are to be made while no request is in flight.
`default_nettype none

module tag_writer_key_repeat_sequencer (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [twkrs_pkg::AddrW-1:0] paddr,
  input  logic [twkrs_pkg::DataW-1:0] pwdata,
  output logic [twkrs_pkg::DataW-1:0] prdata,
  output logic                        pready,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic                        key_up_i,
  input  logic                        key_down_i,
  input  logic [1:0]                  write_outcome_i,
  input  logic                        field_empty_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [9:0]                  selected_o,
  output logic                        removing_o,
  output logic                        number_changed_o,
  output logic                        write_slot_o,
  output logic [1:0]                  result_shown_o,
  output logic                        removal_prompt_o
);
  import twkrs_pkg::*;

  cfg_t   cfg;
  item_t  item_q, item_d;
  logic   item_valid_q;
  state_t state_q, state_d;
  res_t   res_q, res_d;
  logic   res_valid_q;
  logic   in_fire, advance;

  twkrs_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  twkrs_step u_step (
    .cfg_i   (cfg),
    .state_i (state_q),
    .item_i  (item_q),
    .state_o (state_d),
    .res_o   (res_d)
  );

  assign advance    = item_valid_q && (!res_valid_q || out_ready_i);
  assign in_ready_o = !item_valid_q || advance;
  assign in_fire    = in_valid_i && in_ready_o;

  assign item_d = '{key_up: key_up_i, key_down: key_down_i,
                    write_outcome: write_outcome_i, field_empty: field_empty_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
      res_valid_q  <= 1'b0;
      state_q      <= STATE_RST;
    end else begin
      if (in_ready_o) begin
        item_valid_q <= in_valid_i;
      end
      if (advance) begin
        state_q     <= state_d;
        res_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      item_q <= item_d;
    end
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o      = res_valid_q;
  assign selected_o       = res_q.selected;
  assign removing_o       = res_q.removing;
  assign number_changed_o = res_q.number_changed;
  assign write_slot_o     = res_q.write_slot;
  assign result_shown_o   = res_q.result_shown;
  assign removal_prompt_o = res_q.removal_prompt;

endmodule

`default_nettype wire

### sv/twkrs_checker.sv
// Port-level checker of the tag writer key repeat sequencer, bound to the top level.
// Depends on twkrs_pkg and on tag_writer_key_repeat_sequencer_assert.svh for the macros.
`default_nettype none

`include "tag_writer_key_repeat_sequencer_assert.svh"

module twkrs_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [9:0] selected_o,
  input logic       removing_o,
  input logic       write_slot_o,
  input logic [1:0] result_shown_o,
  input logic       removal_prompt_o
);
  import twkrs_pkg::*;

  // A stalled result holds its place and its number.
  `TWKRS_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o && $stable(selected_o))

  // The selected number never drops below one.
  `TWKRS_ASSERT(a_selected_nonzero, clk_i, rst_ni, out_valid_o, selected_o >= NUM_MIN)

  // A shown result comes only from a write slot and always enters removing mode.
  `TWKRS_ASSERT(a_shown_slot, clk_i, rst_ni, out_valid_o && result_shown_o != SHOWN_NONE, write_slot_o && removing_o && (result_shown_o == SHOWN_OK || result_shown_o == SHOWN_ERR))

  // The removal prompt belongs to removing mode, never to a write slot.
  `TWKRS_ASSERT(a_prompt_no_slot, clk_i, rst_ni, out_valid_o && removal_prompt_o, !write_slot_o)

endmodule

bind tag_writer_key_repeat_sequencer twkrs_checker u_twkrs_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .out_valid_o      (out_valid_o),
  .out_ready_i      (out_ready_i),
  .selected_o       (selected_o),
  .removing_o       (removing_o),
  .write_slot_o     (write_slot_o),
  .result_shown_o   (result_shown_o),
  .removal_prompt_o (removal_prompt_o)
);

`default_nettype wire

### verif/tb.sv
`timescale 1ns / 1ps
// Testbench of tag_writer_key_repeat_sequencer: ticks are driven over valid/ready and every
// result is checked against an in-bench prediction of the key, poll and removal logic.
// Depends on twkrs_pkg and the RTL of the block only.

module tb;
  import twkrs_pkg::*;

  localparam logic [1:0] OUTCOME_BAD = 2'd2;
  localparam logic [1:0] OUTCOME_ODD = 2'd3;
  localparam int unsigned STALL_LIMIT = 3000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [AddrW-1:0]  paddr = '0;
  logic [DataW-1:0]  pwdata = '0;
  logic [DataW-1:0]  prdata;
  logic              pready;

  logic       in_valid_i = 1'b0;
  logic       in_ready_o;
  logic       key_up_i = 1'b0;
  logic       key_down_i = 1'b0;
  logic [1:0] write_outcome_i = 2'd0;
  logic       field_empty_i = 1'b0;
  logic       out_valid_o;
  logic       out_ready_i = 1'b0;
  logic [9:0] selected_o;
  logic       removing_o;
  logic       number_changed_o;
  logic       write_slot_o;
  logic [1:0] result_shown_o;
  logic       removal_prompt_o;

  tag_writer_key_repeat_sequencer dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .key_up_i         (key_up_i),
    .key_down_i       (key_down_i),
    .write_outcome_i  (write_outcome_i),
    .field_empty_i    (field_empty_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .selected_o       (selected_o),
    .removing_o       (removing_o),
    .number_changed_o (number_changed_o),
    .write_slot_o     (write_slot_o),
    .result_shown_o   (result_shown_o),
    .removal_prompt_o (removal_prompt_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Predicted copy of the block: its registers and its state.
  cfg_t knobs = '{
    debounce_ticks: DEBOUNCE_RST,
    initial_delay:  INITIAL_DELAY_RST,
    repeat_period:  REPEAT_PERIOD_RST,
    poll_period:    POLL_PERIOD_RST,
    result_hold:    RESULT_HOLD_RST,
    empty_needed:   EMPTY_NEEDED_RST,
    top_number:     TOP_NUMBER_RST
  };
  state_t sq = STATE_RST;

  item_t       ticks_pending[$];
  res_t        due_results[$];
  item_t       on_bus;
  res_t        due_head;
  int unsigned mismatches = 0;
  int unsigned drv_gap = 0;
  int unsigned drv_calm = 0;
  int unsigned mon_hold = 0;
  int unsigned mon_calm = 0;
  int unsigned quiet_cycles = 0;
  bit          no_gaps = 1'b0;

  function automatic logic [15:0] aged(logic [15:0] c);
    return (c == CNT_MAX) ? c : c + 16'd1;
  endfunction

  function automatic logic [9:0] nudged(logic [1:0] keys, logic [9:0] n);
    if (keys == KEYS_UP && n < knobs.top_number) return n + 10'd1;
    if (keys == KEYS_DOWN && n > NUM_MIN) return n - 10'd1;
    return n;
  endfunction

  function automatic res_t advance_sequencer(item_t t);
    logic [1:0] keys;
    logic [9:0] prior;
    res_t       r;
    keys  = {t.key_down, t.key_up};
    prior = sq.number;
    r     = '0;
    sq.since_key_change = aged(sq.since_key_change);
    sq.since_step       = aged(sq.since_step);
    sq.since_poll       = aged(sq.since_poll);
    sq.since_result     = aged(sq.since_result);
    if (keys != sq.raw_keys) begin
      sq.raw_keys = keys;
      sq.since_key_change = '0;
    end
    if (sq.mode_removing) begin
      // Keys are tracked but never act while a tag is being removed.
      sq.stable_keys = sq.raw_keys;
      sq.since_step  = '0;
      sq.in_repeat   = 1'b0;
    end else if (sq.since_key_change >= knobs.debounce_ticks) begin
      if (sq.stable_keys != sq.raw_keys) begin
        sq.stable_keys = sq.raw_keys;
        sq.since_step  = '0;
        sq.in_repeat   = 1'b0;
        sq.number      = nudged(sq.stable_keys, sq.number);
      end else if (sq.stable_keys == KEYS_UP || sq.stable_keys == KEYS_DOWN) begin
        if (sq.since_step >= (sq.in_repeat ? knobs.repeat_period : knobs.initial_delay)) begin
          sq.since_step = '0;
          sq.in_repeat  = 1'b1;
          sq.number     = nudged(sq.stable_keys, sq.number);
        end
      end
    end
    if (sq.since_poll >= knobs.poll_period) begin
      sq.since_poll = '0;
      if (sq.mode_removing) begin
        if (sq.since_result >= knobs.result_hold) begin
          if (sq.last_ok && !sq.prompt_done) begin
            r.removal_prompt = 1'b1;
            sq.prompt_done   = 1'b1;
          end
          if (!t.field_empty) begin
            sq.empty_count = '0;
          end else begin
            if (sq.empty_count < EMPTY_MAX) sq.empty_count = sq.empty_count + 4'd1;
            if (sq.empty_count >= knobs.empty_needed) begin
              sq.empty_count = '0;
              if (sq.last_ok && sq.number < knobs.top_number) sq.number = sq.number + 10'd1;
              sq.mode_removing = 1'b0;
            end
          end
        end
      end else begin
        r.write_slot = 1'b1;
        if (t.write_outcome != OUTCOME_NONE) begin
          sq.last_ok       = (t.write_outcome == OUTCOME_OK);
          r.result_shown   = sq.last_ok ? SHOWN_OK : SHOWN_ERR;
          sq.empty_count   = '0;
          sq.prompt_done   = 1'b0;
          sq.since_result  = '0;
          sq.mode_removing = 1'b1;
        end
      end
    end
    r.selected       = sq.number;
    r.removing       = sq.mode_removing;
    r.number_changed = (sq.number != prior);
    return r;
  endfunction

  // Per-request or per-result wait, with stretches of back-to-back traffic mixed in.
  function automatic int unsigned pick_wait(inout int unsigned calm);
    if (no_gaps) return 0;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 29) == 0) calm = $urandom_range(10, 40);
    return $urandom_range(0, 13);
  endfunction

  function automatic void note_mismatch(string field, int unsigned want, int unsigned got);
    mismatches++;
    $error("%s: expected %0d, got %0d", field, want, got);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      drv_gap = 0;
    end else begin
      if (in_valid_i && in_ready_o) due_results.push_back(advance_sequencer(on_bus));
      if (!in_valid_i || in_ready_o) begin
        if (drv_gap > 0) begin
          drv_gap--;
          in_valid_i <= 1'b0;
        end else if (ticks_pending.size() != 0) begin
          on_bus = ticks_pending.pop_front();
          in_valid_i      <= 1'b1;
          key_up_i        <= on_bus.key_up;
          key_down_i      <= on_bus.key_down;
          write_outcome_i <= on_bus.write_outcome;
          field_empty_i   <= on_bus.field_empty;
          drv_gap = pick_wait(drv_calm);
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      mon_hold = 0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (due_results.size() == 0) begin
          mismatches++;
          $error("result arrived with no request outstanding");
        end else begin
          due_head = due_results.pop_front();
          if (selected_o !== due_head.selected)
            note_mismatch("selected", due_head.selected, selected_o);
          if (removing_o !== due_head.removing)
            note_mismatch("removing", due_head.removing, removing_o);
          if (number_changed_o !== due_head.number_changed)
            note_mismatch("number_changed", due_head.number_changed, number_changed_o);
          if (write_slot_o !== due_head.write_slot)
            note_mismatch("write_slot", due_head.write_slot, write_slot_o);
          if (result_shown_o !== due_head.result_shown)
            note_mismatch("result_shown", due_head.result_shown, result_shown_o);
          if (removal_prompt_o !== due_head.removal_prompt)
            note_mismatch("removal_prompt", due_head.removal_prompt, removal_prompt_o);
        end
        mon_hold = pick_wait(mon_calm);
      end
      if (mon_hold > 0) begin
        mon_hold--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || (psel && penable))
    begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == STALL_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic apb_write(logic [2:0] idx, logic [31:0] word);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= word;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    case (idx)
      REG_DEBOUNCE:      knobs.debounce_ticks = word[15:0];
      REG_INITIAL_DELAY: knobs.initial_delay  = word[15:0];
      REG_REPEAT_PERIOD: knobs.repeat_period  = word[15:0];
      REG_POLL_PERIOD:   knobs.poll_period    = word[15:0];
      REG_RESULT_HOLD:   knobs.result_hold    = word[15:0];
      REG_EMPTY_NEEDED:  knobs.empty_needed   = word[3:0];
      REG_TOP_NUMBER:    knobs.top_number     = word[9:0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  // Bits above each register's width carry random junk that the block must drop.
  task automatic program_regs(cfg_t c);
    logic [31:0] word;
    word = $urandom(); word[15:0] = c.debounce_ticks; apb_write(REG_DEBOUNCE, word);
    word = $urandom(); word[15:0] = c.initial_delay;  apb_write(REG_INITIAL_DELAY, word);
    word = $urandom(); word[15:0] = c.repeat_period;  apb_write(REG_REPEAT_PERIOD, word);
    word = $urandom(); word[15:0] = c.poll_period;    apb_write(REG_POLL_PERIOD, word);
    word = $urandom(); word[15:0] = c.result_hold;    apb_write(REG_RESULT_HOLD, word);
    word = $urandom(); word[3:0]  = c.empty_needed;   apb_write(REG_EMPTY_NEEDED, word);
    word = $urandom(); word[9:0]  = c.top_number;     apb_write(REG_TOP_NUMBER, word);
  endtask

  task automatic queue_ticks(bit up, bit down, logic [1:0] outcome, bit vacant,
                             int unsigned count);
    item_t t;
    t.key_up        = up;
    t.key_down      = down;
    t.write_outcome = outcome;
    t.field_empty   = vacant;
    repeat (count) ticks_pending.push_back(t);
  endtask

  // Key presses held for a while with some contact bounce, rare write results and
  // runs of empty or occupied field probes.
  task automatic queue_random_ticks(int unsigned count);
    item_t       t;
    logic [1:0]  level;
    int unsigned run_left;
    bit          vacant;
    level    = '0;
    run_left = 0;
    vacant   = 1'b0;
    repeat (count) begin
      if (run_left == 0) begin
        level    = 2'($urandom_range(0, 3));
        run_left = $urandom_range(1, 24);
      end
      run_left--;
      t.key_up   = level[0];
      t.key_down = level[1];
      if ($urandom_range(0, 11) == 0) begin
        if ($urandom_range(0, 1)) t.key_up = !t.key_up;
        else t.key_down = !t.key_down;
      end
      case ($urandom_range(0, 15))
        0:       t.write_outcome = OUTCOME_OK;
        1:       t.write_outcome = OUTCOME_BAD;
        2:       t.write_outcome = OUTCOME_ODD;
        default: t.write_outcome = OUTCOME_NONE;
      endcase
      if ($urandom_range(0, 9) == 0) vacant = !vacant;
      t.field_empty = vacant;
      ticks_pending.push_back(t);
    end
  endtask

  function automatic cfg_t draw_settings(int unsigned flavor);
    cfg_t c;
    c.debounce_ticks = 16'($urandom_range(0, 4));
    c.initial_delay  = 16'($urandom_range(1, 8));
    c.repeat_period  = 16'($urandom_range(1, 4));
    c.poll_period    = 16'($urandom_range(1, 6));
    c.result_hold    = 16'($urandom_range(0, 10));
    c.empty_needed   = 4'($urandom_range(1, 4));
    c.top_number     = 10'($urandom_range(2, 40));
    case (flavor)
      1: begin
        c.debounce_ticks = '0;
        c.result_hold    = '0;
        c.initial_delay  = 16'd1;
        c.repeat_period  = 16'd1;
        c.poll_period    = 16'd1;
        c.empty_needed   = 4'd1;
      end
      2: begin
        c.debounce_ticks = 16'($urandom_range(5, 12));
        c.initial_delay  = 16'($urandom_range(10, 30));
        c.poll_period    = 16'($urandom_range(4, 20));
        c.result_hold    = 16'($urandom_range(10, 60));
        c.top_number     = 10'($urandom_range(1, 1023));
      end
      3: begin
        c.top_number   = 10'($urandom_range(1, 3));
        c.poll_period  = 16'd1;
        c.result_hold  = '0;
        c.empty_needed = EMPTY_MAX;
      end
      default: ;
    endcase
    return c;
  endfunction

  // Holds the sender back until every request has produced its result.
  task automatic settle();
    while (ticks_pending.size() != 0 || in_valid_i || due_results.size() != 0)
      @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  initial begin
    cfg_t c;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings: every key pair, every outcome code and both probe levels.
    for (int i = 0; i < 8; i++) queue_ticks(i[0], i[1], i[2:1], i[2], 1);
    settle();

    // Zero delays and periods, zero empty probes needed, largest top number.
    c = knobs;
    c.debounce_ticks = '0;
    c.initial_delay  = '0;
    c.repeat_period  = '0;
    c.poll_period    = '0;
    c.result_hold    = '0;
    c.empty_needed   = '0;
    c.top_number     = 10'd1023;
    program_regs(c);
    queue_ticks(1'b1, 1'b0, OUTCOME_NONE, 1'b0, 4);
    queue_ticks(1'b1, 1'b1, OUTCOME_NONE, 1'b0, 2);
    queue_ticks(1'b0, 1'b1, OUTCOME_NONE, 1'b0, 2);
    queue_ticks(1'b0, 1'b0, OUTCOME_OK, 1'b0, 1);
    queue_ticks(1'b1, 1'b0, OUTCOME_NONE, 1'b0, 1);
    queue_ticks(1'b0, 1'b0, OUTCOME_NONE, 1'b1, 1);
    queue_ticks(1'b0, 1'b0, OUTCOME_ODD, 1'b0, 1);
    queue_ticks(1'b0, 1'b1, OUTCOME_NONE, 1'b1, 1);
    settle();

    // Top number of zero leaves the current number above the limit.
    c.top_number = '0;
    program_regs(c);
    queue_ticks(1'b1, 1'b0, OUTCOME_NONE, 1'b0, 2);
    queue_ticks(1'b0, 1'b1, OUTCOME_NONE, 1'b0, 2);
    settle();

    for (int unsigned p = 0; p < 8; p++) begin
      program_regs(draw_settings(p % 4));
      queue_random_ticks(195);
      settle();
    end

    // Largest delays: within a short run no key, poll or removal action fires.
    c.debounce_ticks = CNT_MAX;
    c.initial_delay  = CNT_MAX;
    c.repeat_period  = CNT_MAX;
    c.poll_period    = CNT_MAX;
    c.result_hold    = CNT_MAX;
    c.empty_needed   = EMPTY_MAX;
    c.top_number     = 10'd1023;
    program_regs(c);
    no_gaps = 1'b1;
    queue_ticks(1'b1, 1'b0, OUTCOME_OK, 1'b1, 40);
    settle();

    repeat (8) @(posedge clk_i);
    if (mismatches == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule

### files.f
+incdir+sv
sv/twkrs_pkg.sv
sv/twkrs_cfg_regs.sv
sv/twkrs_step.sv
sv/tag_writer_key_repeat_sequencer.sv
sv/twkrs_checker.sv
verif/tb.sv
